// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the shift cipher secrecy checker RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked only while out of reset.
`define SCSC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Overlapping implication, checked only while out of reset.
`define SCSC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/scsc_pkg.sv =====
// Shared constants, types and helpers for the shift cipher secrecy checker.
// No dependencies.
`default_nettype none

package scsc_pkg;

    localparam int CNT_W     = 16;           // histogram counter width
    localparam int TOL_W     = 8;
    localparam int IDX_W     = 5;            // letter index width
    localparam int LETTERS   = 26;
    localparam int ADDR_W    = 2 * IDX_W;    // pair memory address {y, x}
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PROD_W    = 3 * CNT_W;    // shared multiplier result
    localparam int ACC_W     = 2 * CNT_W + TOL_W;

    localparam logic [7:0]       LETTER_A  = 8'd65;
    localparam logic [7:0]       LETTER_Z  = 8'd90;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LETTERS - 1);
    localparam logic [IDX_W-1:0] NUM_LTRS  = IDX_W'(LETTERS);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(20);

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    // Saturating increment
    function automatic cnt_t bump_cnt(input cnt_t c);
        bump_cnt = (c == '1) ? c : c + cnt_t'(1);
    endfunction

    // (a - b) mod 26 for a, b in 0..25
    function automatic idx_t sub_mod(input idx_t a, input idx_t b);
        sub_mod = (a >= b) ? idx_t'(a - b) : idx_t'(a + NUM_LTRS - b);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/shift_cipher_secrecy_checker.sv =====
// Shift cipher secrecy checker: encrypts and counts letter samples, then
// checks every (cipher, plain) pair on an evaluate beat. Uses scsc_pkg.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+----------------------------------
//  s_        | in  | s_valid / s_ready  | s_func, s_plain_byte, s_shift_key
//  m_        | out | m_valid / m_ready  | m_cipher_byte, m_perfect, m_overflow
//  cfg_      | in  | cfg_wr_en          | cfg_wr_data (tolerance reciprocal)
//
// Sample beat: histograms update on the accept edge.
// Evaluate beat: 676 pairs, each through READ, MUL1, MUL2, MUL3 and CMP,
//   one multiplier shared by the three products of each pair; pair memory
//   clears as it goes, counters clear with the last pair.
// Reset: the pair memory is swept to zero over all 676 pairs with s_ready low.
// s_ready needs the output register free or being taken this cycle.
`default_nettype none

module shift_cipher_secrecy_checker
    import scsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_func,
    input  wire logic [7:0]       s_plain_byte,
    input  wire logic [4:0]       s_shift_key,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_cipher_byte,
    output logic                  m_perfect,
    output logic                  m_overflow,
    input  wire logic             cfg_wr_en,
    input  wire logic [TOL_W-1:0] cfg_wr_data
);

    `include "assert_macros.svh"

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL1  = 3'd3;
    localparam logic [2:0] ST_MUL2  = 3'd4;
    localparam logic [2:0] ST_MUL3  = 3'd5;
    localparam logic [2:0] ST_CMP   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [TOL_W-1:0] tol_reg;
    idx_t             y_reg, x_reg;
    logic             last_pair;

    cnt_t total_reg;
    cnt_t plain_cnt_reg  [LETTERS];
    cnt_t cipher_cnt_reg [LETTERS];
    cnt_t key_cnt_reg    [LETTERS];
    logic sat_reg;

    logic pair_mem [MEM_DEPTH];
    logic seen_reg;

    cnt_t             ny_reg, nx_reg, kc_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [2*CNT_W-1:0] rhs_reg;
    logic             ok_reg;

    logic [7:0] m_cipher_reg;
    logic       m_valid_reg, m_perfect_reg, m_overflow_reg;

    // ---------------- sample path ----------------
    logic       accept, smp_go, eval_go, is_letter;
    idx_t       s_x, s_k, s_y;
    logic [IDX_W:0] y_sum;
    logic       sat_hit, sat_next;
    logic [7:0] s_cipher;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign smp_go  = accept && !s_func;
    assign eval_go = accept && s_func;

    always_comb begin
        is_letter = (s_plain_byte >= LETTER_A) && (s_plain_byte <= LETTER_Z);
        s_x       = idx_t'(s_plain_byte - LETTER_A);
        s_k       = (s_shift_key >= NUM_LTRS) ? idx_t'(s_shift_key - NUM_LTRS) : s_shift_key;
        y_sum     = {1'b0, s_x} + {1'b0, s_k};
        s_y       = (y_sum >= {1'b0, NUM_LTRS}) ? idx_t'(y_sum - {1'b0, NUM_LTRS})
                                                : idx_t'(y_sum);
        s_cipher  = is_letter ? (8'(s_y) + LETTER_A) : s_plain_byte;
        sat_hit   = (total_reg == '1) || (plain_cnt_reg[s_x] == '1)
                 || (cipher_cnt_reg[s_y] == '1) || (key_cnt_reg[s_k] == '1);
        sat_next  = sat_reg || (is_letter && sat_hit);
    end

    // ---------------- shared multiplier ----------------
    cnt_t               nk, diff;
    logic [2*CNT_W-1:0] mul_a;
    cnt_t               mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic               pair_pass;

    always_comb begin
        nk   = seen_reg ? kc_reg : '0;
        diff = (nk >= ny_reg) ? nk - ny_reg : ny_reg - nk;
        unique case (state_reg)
            ST_MUL1: begin
                mul_a = (2*CNT_W)'(diff);
                mul_b = nx_reg;
            end
            ST_MUL2: begin
                mul_a = acc_reg[2*CNT_W-1:0];
                mul_b = CNT_W'(tol_reg);
            end
            default: begin
                mul_a = (2*CNT_W)'(total_reg);
                mul_b = ny_reg;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
        pair_pass = (ny_reg != '0) && (total_reg != '0)
                 && ((tol_reg == '0) || (acc_reg <= ACC_W'(rhs_reg)));
    end

    assign last_pair = (y_reg == LAST_IDX) && (x_reg == LAST_IDX);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (last_pair) state_next = ST_IDLE;
            ST_IDLE:  if (eval_go) state_next = ST_READ;
            ST_READ:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_MUL3;
            ST_MUL3:  state_next = ST_CMP;
            ST_CMP:   state_next = last_pair ? ST_IDLE : ST_READ;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            tol_reg   <= TOL_RESET;
            y_reg     <= '0;
            x_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_CLEAR) || (state_reg == ST_CMP)) begin
                if (x_reg == LAST_IDX) begin
                    x_reg <= '0;
                    y_reg <= (y_reg == LAST_IDX) ? '0 : y_reg + idx_t'(1);
                end else begin
                    x_reg <= x_reg + idx_t'(1);
                end
            end
        end
    end

    // ---------------- pair memory ----------------
    logic              mem_we, mem_wd;
    logic [ADDR_W-1:0] mem_wa;

    always_comb begin
        if (smp_go) begin
            mem_we = is_letter;
            mem_wa = {s_y, s_x};
            mem_wd = 1'b1;
        end else begin
            // clear behind the read during reset sweep and evaluate
            mem_we = (state_reg == ST_CLEAR) || (state_reg == ST_READ);
            mem_wa = {y_reg, x_reg};
            mem_wd = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            seen_reg <= pair_mem[{y_reg, x_reg}];
        end
        if (mem_we) begin
            pair_mem[mem_wa] <= mem_wd;
        end
    end

    // ---------------- pair datapath ----------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_READ: begin
                ny_reg <= cipher_cnt_reg[y_reg];
                nx_reg <= plain_cnt_reg[x_reg];
                kc_reg <= key_cnt_reg[sub_mod(y_reg, x_reg)];
            end
            ST_MUL1: acc_reg <= ACC_W'(mul_p);
            ST_MUL2: acc_reg <= ACC_W'(mul_p);
            ST_MUL3: rhs_reg <= (2*CNT_W)'(mul_p);
            default: ;
        endcase
    end

    // ---------------- histograms ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn || ((state_reg == ST_CMP) && last_pair)) begin
            total_reg <= '0;
            sat_reg   <= 1'b0;
            for (int i = 0; i < LETTERS; i++) begin
                plain_cnt_reg[i]  <= '0;
                cipher_cnt_reg[i] <= '0;
                key_cnt_reg[i]    <= '0;
            end
        end else if (smp_go && is_letter) begin
            total_reg         <= bump_cnt(total_reg);
            plain_cnt_reg[s_x]  <= bump_cnt(plain_cnt_reg[s_x]);
            cipher_cnt_reg[s_y] <= bump_cnt(cipher_cnt_reg[s_y]);
            key_cnt_reg[s_k]    <= bump_cnt(key_cnt_reg[s_k]);
            sat_reg           <= sat_next;
        end
    end

    // ---------------- verdict and output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg      <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (eval_go) begin
                ok_reg <= 1'b1;
            end else if (state_reg == ST_CMP) begin
                ok_reg <= ok_reg && pair_pass;
            end

            if (smp_go) begin
                m_valid_reg <= 1'b1;
            end else if ((state_reg == ST_CMP) && last_pair) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (smp_go) begin
            m_cipher_reg   <= s_cipher;
            m_perfect_reg  <= 1'b0;
            m_overflow_reg <= sat_next;
        end else if ((state_reg == ST_CMP) && last_pair) begin
            m_cipher_reg   <= 8'd0;
            m_perfect_reg  <= ok_reg && pair_pass;
            m_overflow_reg <= sat_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cipher_byte = m_cipher_reg;
    assign m_perfect     = m_perfect_reg;
    assign m_overflow    = m_overflow_reg;

    // ---------------- assertions ----------------
    `SCSC_ASSERT_IMPL(a_busy_no_out, (state_reg != ST_IDLE), !m_valid_reg,
        "result pending while sweep runs")
    `SCSC_ASSERT(a_clear_after_eval,
        ((state_reg == ST_CMP) && last_pair) |=> ((total_reg == '0) && !sat_reg),
        "state not cleared after evaluate")
    `SCSC_ASSERT_IMPL(a_plain_le_total, (state_reg == ST_MUL1), (nx_reg <= total_reg),
        "plain count exceeds letter total")
    `SCSC_ASSERT_IMPL(a_sat_with_beat, $rose(sat_reg), m_valid_reg && m_overflow_reg,
        "saturation without a sample result")

endmodule

`default_nettype wire
